### rtl/pqd_pkg.sv
package pqd_pkg;

	localparam int PRIO_BITS     = 3;
	localparam int END_BITS      = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 4;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int SLOT_COUNT_DEF  = 10;
	localparam int ID_BITS_DEF     = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_MODE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_URGENT_MAX  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SERIOUS_MAX = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_END   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_END  = 3'd4;

	localparam logic                 ORDER_MODE_RST  = 1'b1;
	localparam logic [PRIO_BITS-1:0] URGENT_MAX_RST  = 3'd2;
	localparam logic [PRIO_BITS-1:0] SERIOUS_MAX_RST = 3'd4;
	localparam logic [END_BITS-1:0]  FIRST_END_RST   = 4'd3;
	localparam logic [END_BITS-1:0]  SECOND_END_RST  = 4'd7;

	typedef struct packed {
		logic                 order_mode;
		logic [PRIO_BITS-1:0] urgent_max;
		logic [PRIO_BITS-1:0] serious_max;
		logic [END_BITS-1:0]  first_end;
		logic [END_BITS-1:0]  second_end;
	} cfg_t;

	typedef struct packed {
		logic                 ins;
		logic                 pop;
		logic                 order_mode;
		logic [PRIO_BITS-1:0] prio;
	} cell_ctl_t;

endpackage

### rtl/pqd_cell.sv
module pqd_cell #(
	parameter int ID_BITS = pqd_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pqd_pkg::cell_ctl_t            ctl,
	input  logic [ID_BITS-1:0]            new_id,
	input  logic                          left_v,
	input  logic [ID_BITS-1:0]            left_id,
	input  logic [pqd_pkg::PRIO_BITS-1:0] left_prio,
	input  logic                          right_v,
	input  logic [ID_BITS-1:0]            right_id,
	input  logic [pqd_pkg::PRIO_BITS-1:0] right_prio,
	input  logic                          found_in,
	output logic                          found_out,
	output logic                          v,
	output logic [ID_BITS-1:0]            id,
	output logic [pqd_pkg::PRIO_BITS-1:0] prio
);

	logic                          v_q;
	logic [ID_BITS-1:0]            id_q;
	logic [pqd_pkg::PRIO_BITS-1:0] prio_q;
	logic                          hit;

	assign hit       = !v_q || (ctl.order_mode && (prio_q > ctl.prio));
	assign found_out = found_in || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.pop) begin
			v_q <= right_v;
		end else if (ctl.ins) begin
			if (found_in) begin
				v_q <= left_v;
			end else if (hit) begin
				v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			id_q   <= right_id;
			prio_q <= right_prio;
		end else if (ctl.ins) begin
			if (found_in) begin
				id_q   <= left_id;
				prio_q <= left_prio;
			end else if (hit) begin
				id_q   <= new_id;
				prio_q <= ctl.prio;
			end
		end
	end

	assign v    = v_q;
	assign id   = id_q;
	assign prio = prio_q;

endmodule

### rtl/pqd_slot_pick.sv
module pqd_slot_pick #(
	parameter int SLOT_COUNT = pqd_pkg::SLOT_COUNT_DEF,
	parameter int SLOT_BITS  = 4
) (
	input  pqd_pkg::cfg_t                 cfg,
	input  logic [pqd_pkg::PRIO_BITS-1:0] prio,
	input  logic [SLOT_COUNT-1:0]         busy,
	output logic                          found,
	output logic [SLOT_BITS-1:0]          slot,
	output logic [SLOT_COUNT-1:0]         mask
);

	localparam int W = SLOT_BITS + 1;

	logic [W-1:0]          lo;
	logic [W-1:0]          hi;
	logic [SLOT_COUNT-1:0] cand;

	always_comb begin
		if (prio <= cfg.urgent_max) begin
			lo = '0;
			hi = W'(cfg.first_end);
		end else if (prio <= cfg.serious_max) begin
			lo = W'(cfg.first_end) + W'(1);
			hi = W'(cfg.second_end);
		end else begin
			lo = W'(cfg.second_end) + W'(1);
			hi = {W{1'b1}};
		end
	end

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			cand[i] = !busy[i] && (W'(i) >= lo) && (W'(i) <= hi);
		end
	end

	assign mask  = cand & (~cand + SLOT_COUNT'(1));
	assign found = |cand;

	always_comb begin
		slot = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (mask[i]) begin
				slot = slot | SLOT_BITS'(i);
			end
		end
	end

endmodule

### rtl/priority_queue_pool_dispatcher.sv
// Request queue with pooled slot dispatch.
// Input channel (in_valid / in_stall) carries one item per step: an optional
// arrival with its priority and an optional slot release. The item is
// applied in the cycle it is accepted (insert into the queue, free the slot);
// the dispatch step that follows looks at the queue head and, if its pool
// has a free slot, gives it the lowest one and pops it. Every item yields
// exactly one result item on the output channel (out_valid / out_stall),
// held in an output register. No new item is taken until the dispatch
// step of the last item has run; in_stall is high meanwhile.
// While out_stall holds a result, the block still takes one more item and
// applies it; its dispatch cycle then waits for the output register and
// in_stall stays high meanwhile.
// Reset empties the queue, frees all slots, sets the next id to one and
// loads the default pool configuration. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and belong between items.
module priority_queue_pool_dispatcher #(
	parameter int QUEUE_DEPTH = pqd_pkg::QUEUE_DEPTH_DEF,
	parameter int SLOT_COUNT  = pqd_pkg::SLOT_COUNT_DEF,
	parameter int ID_BITS     = pqd_pkg::ID_BITS_DEF,
	parameter int SLOT_BITS   = ($clog2(SLOT_COUNT) > pqd_pkg::END_BITS) ?
		$clog2(SLOT_COUNT) : pqd_pkg::END_BITS,
	parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pqd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pqd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              arrival_valid,
	input  logic [pqd_pkg::PRIO_BITS-1:0]     arrival_priority,
	input  logic                              release_valid,
	input  logic [SLOT_BITS-1:0]              release_slot,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              dispatched,
	output logic [ID_BITS-1:0]                dispatched_id,
	output logic [pqd_pkg::PRIO_BITS-1:0]     dispatched_priority,
	output logic [SLOT_BITS-1:0]              dispatched_slot,
	output logic                              arrival_dropped,
	output logic [CNT_BITS-1:0]               queue_count
);

	pqd_pkg::cfg_t      cfg_q;
	pqd_pkg::cell_ctl_t ctl;

	logic                  busy_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [ID_BITS-1:0]    next_id_q;
	logic [SLOT_COUNT-1:0] slot_map_q;
	logic                  dropped_s1;

	logic                          out_valid_q;
	logic                          disp_q;
	logic [ID_BITS-1:0]            disp_id_q;
	logic [pqd_pkg::PRIO_BITS-1:0] disp_prio_q;
	logic [SLOT_BITS-1:0]          disp_slot_q;
	logic                          dropped_q;
	logic [CNT_BITS-1:0]           qcount_q;

	logic                          accept;
	logic                          full;
	logic                          ins;
	logic                          disp_go;
	logic                          pop;
	logic                          pick_found;
	logic [SLOT_BITS-1:0]          pick_slot;
	logic [SLOT_COUNT-1:0]         pick_mask;
	logic [SLOT_COUNT-1:0]         rel_mask;

	logic [QUEUE_DEPTH-1:0]                        cell_v;
	logic [QUEUE_DEPTH-1:0][ID_BITS-1:0]           cell_id;
	logic [QUEUE_DEPTH-1:0][pqd_pkg::PRIO_BITS-1:0] cell_prio;
	logic [QUEUE_DEPTH:0]                          found;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign full     = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign ins      = accept && arrival_valid && !full;
	assign disp_go  = busy_q && (!out_valid_q || !out_stall);
	assign pop      = disp_go && cell_v[0] && pick_found;

	assign ctl.ins        = ins;
	assign ctl.pop        = pop;
	assign ctl.order_mode = cfg_q.order_mode;
	assign ctl.prio       = arrival_priority;

	assign found[0] = 1'b0;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic                          lv;
		logic [ID_BITS-1:0]            lid;
		logic [pqd_pkg::PRIO_BITS-1:0] lprio;
		logic                          rv;
		logic [ID_BITS-1:0]            rid;
		logic [pqd_pkg::PRIO_BITS-1:0] rprio;

		if (g == 0) begin : g_head
			assign lv    = 1'b0;
			assign lid   = '0;
			assign lprio = '0;
		end else begin : g_left
			assign lv    = cell_v[g-1];
			assign lid   = cell_id[g-1];
			assign lprio = cell_prio[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign rv    = 1'b0;
			assign rid   = '0;
			assign rprio = '0;
		end else begin : g_right
			assign rv    = cell_v[g+1];
			assign rid   = cell_id[g+1];
			assign rprio = cell_prio[g+1];
		end

		pqd_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_id    (next_id_q),
			.left_v    (lv),
			.left_id   (lid),
			.left_prio (lprio),
			.right_v   (rv),
			.right_id  (rid),
			.right_prio(rprio),
			.found_in  (found[g]),
			.found_out (found[g+1]),
			.v         (cell_v[g]),
			.id        (cell_id[g]),
			.prio      (cell_prio[g])
		);
	end

	pqd_slot_pick #(
		.SLOT_COUNT(SLOT_COUNT),
		.SLOT_BITS (SLOT_BITS)
	) u_pick (
		.cfg  (cfg_q),
		.prio (cell_prio[0]),
		.busy (slot_map_q),
		.found(pick_found),
		.slot (pick_slot),
		.mask (pick_mask)
	);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			rel_mask[i] = release_valid && (release_slot == SLOT_BITS'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order_mode  <= pqd_pkg::ORDER_MODE_RST;
			cfg_q.urgent_max  <= pqd_pkg::URGENT_MAX_RST;
			cfg_q.serious_max <= pqd_pkg::SERIOUS_MAX_RST;
			cfg_q.first_end   <= pqd_pkg::FIRST_END_RST;
			cfg_q.second_end  <= pqd_pkg::SECOND_END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pqd_pkg::CFG_ORDER_MODE: begin
					cfg_q.order_mode <= cfg_data[0];
				end
				pqd_pkg::CFG_URGENT_MAX: begin
					cfg_q.urgent_max <= cfg_data[pqd_pkg::PRIO_BITS-1:0];
				end
				pqd_pkg::CFG_SERIOUS_MAX: begin
					cfg_q.serious_max <= cfg_data[pqd_pkg::PRIO_BITS-1:0];
				end
				pqd_pkg::CFG_FIRST_END: begin
					cfg_q.first_end <= cfg_data[pqd_pkg::END_BITS-1:0];
				end
				pqd_pkg::CFG_SECOND_END: begin
					cfg_q.second_end <= cfg_data[pqd_pkg::END_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			next_id_q   <= ID_BITS'(1);
			slot_map_q  <= '0;
			dropped_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			disp_q      <= 1'b0;
			disp_id_q   <= '0;
			disp_prio_q <= '0;
			disp_slot_q <= '0;
			dropped_q   <= 1'b0;
			qcount_q    <= '0;
		end else begin
			if (accept) begin
				busy_q     <= 1'b1;
				dropped_s1 <= arrival_valid && full;
				slot_map_q <= slot_map_q & ~rel_mask;
				if (ins) begin
					count_q   <= count_q + CNT_BITS'(1);
					next_id_q <= next_id_q + ID_BITS'(1);
				end
				if (out_valid_q && !out_stall) begin
					out_valid_q <= 1'b0;
				end
			end else if (disp_go) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				disp_q      <= pop;
				disp_id_q   <= pop ? cell_id[0] : '0;
				disp_prio_q <= pop ? cell_prio[0] : '0;
				disp_slot_q <= pop ? pick_slot : '0;
				dropped_q   <= dropped_s1;
				qcount_q    <= pop ? count_q - CNT_BITS'(1) : count_q;
				if (pop) begin
					count_q    <= count_q - CNT_BITS'(1);
					slot_map_q <= slot_map_q | pick_mask;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign dispatched          = disp_q;
	assign dispatched_id       = disp_id_q;
	assign dispatched_priority = disp_prio_q;
	assign dispatched_slot     = disp_slot_q;
	assign arrival_dropped     = dropped_q;
	assign queue_count         = qcount_q;

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_v) == 32'(count_q))
		else $error("fill count disagrees with valid cells");

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[0] |-> ($onehot0(pick_mask) && ((pick_mask & slot_map_q) == '0)))
		else $error("slot pick not a single free slot");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cell_v[0])
		else $error("pop from empty queue");

	a_accept_then_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !accept)
		else $error("accept not followed by dispatch cycle");

endmodule

### sim/tb_priority_queue_pool_dispatcher.sv
`timescale 1ns / 1ps

module tb_priority_queue_pool_dispatcher;

	localparam int QDEPTH = pqd_pkg::QUEUE_DEPTH_DEF;
	localparam int SLOTS  = pqd_pkg::SLOT_COUNT_DEF;
	localparam int IDW    = pqd_pkg::ID_BITS_DEF;
	localparam int SLOTW  = ($clog2(SLOTS) > pqd_pkg::END_BITS) ? $clog2(SLOTS) :
		pqd_pkg::END_BITS;
	localparam int CNTW   = $clog2(QDEPTH + 1);
	localparam int PW     = pqd_pkg::PRIO_BITS;

	localparam logic [pqd_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [pqd_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	typedef struct packed {
		logic             arr_v;
		logic [PW-1:0]    arr_prio;
		logic             rel_v;
		logic [SLOTW-1:0] rel_slot;
	} stim_t;

	typedef struct packed {
		logic             disp;
		logic [IDW-1:0]   id;
		logic [PW-1:0]    prio;
		logic [SLOTW-1:0] slot;
		logic             dropped;
		logic [CNTW-1:0]  count;
	} outcome_t;

	typedef struct packed {
		logic [IDW-1:0] id;
		logic [PW-1:0]  prio;
	} req_t;

	typedef struct packed {
		stim_t    s;
		logic     typed;
		outcome_t want;
	} plan_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [pqd_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [pqd_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic                              in_valid;
	logic                              in_stall;
	logic                              arrival_valid;
	logic [PW-1:0]                     arrival_priority;
	logic                              release_valid;
	logic [SLOTW-1:0]                  release_slot;
	logic                              out_valid;
	logic                              out_stall;
	logic                              dispatched;
	logic [IDW-1:0]                    dispatched_id;
	logic [PW-1:0]                     dispatched_priority;
	logic [SLOTW-1:0]                  dispatched_slot;
	logic                              arrival_dropped;
	logic [CNTW-1:0]                   queue_count;

	req_t           backlog[$];
	logic [IDW-1:0] seq_next;
	logic [SLOTS-1:0] slots_busy;
	pqd_pkg::cfg_t  live_cfg;

	outcome_t  owed_results[$];
	plan_row_t opening_rows[$];
	int        mismatches;
	int        offer_gap_pct;
	int        stall_pct;
	int        hold_left;

	priority_queue_pool_dispatcher DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.arrival_valid       (arrival_valid),
		.arrival_priority    (arrival_priority),
		.release_valid       (release_valid),
		.release_slot        (release_slot),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.dispatched          (dispatched),
		.dispatched_id       (dispatched_id),
		.dispatched_priority (dispatched_priority),
		.dispatched_slot     (dispatched_slot),
		.arrival_dropped     (arrival_dropped),
		.queue_count         (queue_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("tb_priority_queue_pool_dispatcher: FAIL");
		$finish;
	end

	task automatic flag(input string what);
		if (mismatches < 40)
			$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic int free_slot(input logic [PW-1:0] p);
		int lo, hi, i, pick;
		pick = -1;
		if (p <= live_cfg.urgent_max) begin
			lo = 0;
			hi = int'(live_cfg.first_end);
		end else if (p <= live_cfg.serious_max) begin
			lo = int'(live_cfg.first_end) + 1;
			hi = int'(live_cfg.second_end);
		end else begin
			lo = int'(live_cfg.second_end) + 1;
			hi = SLOTS - 1;
		end
		if (hi > SLOTS - 1)
			hi = SLOTS - 1;
		for (i = hi; i >= lo; i--)
			if (!slots_busy[i])
				pick = i;
		return pick;
	endfunction

	function automatic outcome_t schedule_step(input stim_t s);
		outcome_t r;
		req_t     head;
		int       pos, i, pick;
		r = '0;
		if (s.arr_v) begin
			if (backlog.size() >= QDEPTH) begin
				r.dropped = 1'b1;
			end else begin
				pos = backlog.size();
				if (live_cfg.order_mode == MODE_PRIO)
					for (i = backlog.size() - 1; i >= 0; i--)
						if (backlog[i].prio > s.arr_prio)
							pos = i;
				backlog.insert(pos, '{seq_next, s.arr_prio});
				seq_next++;
			end
		end
		if (s.rel_v && s.rel_slot < SLOTS)
			slots_busy[s.rel_slot] = 1'b0;
		if (backlog.size() > 0) begin
			pick = free_slot(backlog[0].prio);
			if (pick >= 0) begin
				head = backlog.pop_front();
				r.disp = 1'b1;
				r.id = head.id;
				r.prio = head.prio;
				r.slot = pick[SLOTW-1:0];
				slots_busy[pick] = 1'b1;
			end
		end
		r.count = CNTW'(backlog.size());
		return r;
	endfunction

	function automatic stim_t random_item();
		stim_t s;
		s.arr_v = ($urandom_range(0, 99) < 65);
		s.arr_prio = PW'($urandom_range(0, 7));
		s.rel_v = ($urandom_range(0, 99) < 55);
		s.rel_slot = ($urandom_range(0, 99) < 10) ? SLOTW'($urandom_range(10, 15)) :
			SLOTW'($urandom_range(0, SLOTS - 1));
		return s;
	endfunction

	task automatic add_row(input logic av, input logic [PW-1:0] ap, input logic rv,
		input logic [SLOTW-1:0] rs, input logic typed, input logic d,
		input logic [IDW-1:0] id, input logic [PW-1:0] pr, input logic [SLOTW-1:0] sl,
		input logic dr, input logic [CNTW-1:0] cnt);
		plan_row_t row;
		row.s = '{av, ap, rv, rs};
		row.typed = typed;
		row.want = '{d, id, pr, sl, dr, cnt};
		opening_rows.push_back(row);
	endtask

	task automatic offer(input stim_t s, input logic typed, input outcome_t want);
		outcome_t predicted;
		while ($urandom_range(0, 99) < offer_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		arrival_valid <= s.arr_v;
		arrival_priority <= s.arr_prio;
		release_valid <= s.rel_v;
		release_slot <= s.rel_slot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = schedule_step(s);
		owed_results.push_back(typed ? want : predicted);
	endtask

	task automatic load_reg(input logic [pqd_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [pqd_pkg::CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			pqd_pkg::CFG_ORDER_MODE:  live_cfg.order_mode = val[0];
			pqd_pkg::CFG_URGENT_MAX:  live_cfg.urgent_max = val[PW-1:0];
			pqd_pkg::CFG_SERIOUS_MAX: live_cfg.serious_max = val[PW-1:0];
			pqd_pkg::CFG_FIRST_END:   live_cfg.first_end = val;
			pqd_pkg::CFG_SECOND_END:  live_cfg.second_end = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [3:0] mode, input logic [3:0] urgent,
		input logic [3:0] serious, input logic [3:0] first_end, input logic [3:0] second_end);
		load_reg(pqd_pkg::CFG_ORDER_MODE, mode);
		load_reg(pqd_pkg::CFG_URGENT_MAX, urgent);
		load_reg(pqd_pkg::CFG_SERIOUS_MAX, serious);
		load_reg(pqd_pkg::CFG_FIRST_END, first_end);
		load_reg(pqd_pkg::CFG_SECOND_END, second_end);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int n);
		repeat (n) offer(random_item(), 1'b0, '0);
		settle();
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_watch
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				flag("result with no item pending");
			end else begin
				want = owed_results.pop_front();
				if (dispatched !== want.disp)
					flag($sformatf("dispatched %b want %b", dispatched, want.disp));
				if (dispatched_id !== want.id)
					flag($sformatf("dispatched_id %0d want %0d", dispatched_id, want.id));
				if (dispatched_priority !== want.prio)
					flag($sformatf("dispatched_priority %0d want %0d",
						dispatched_priority, want.prio));
				if (dispatched_slot !== want.slot)
					flag($sformatf("dispatched_slot %0d want %0d", dispatched_slot, want.slot));
				if (arrival_dropped !== want.dropped)
					flag($sformatf("arrival_dropped %b want %b", arrival_dropped, want.dropped));
				if (queue_count !== want.count)
					flag($sformatf("queue_count %0d want %0d", queue_count, want.count));
			end
		end
	end

	initial begin
		int k;
		mismatches = 0;
		offer_gap_pct = 34;
		stall_pct = 34;
		hold_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		arrival_valid = 1'b0;
		arrival_priority = '0;
		release_valid = 1'b0;
		release_slot = '0;
		backlog.delete();
		seq_next = 1;
		slots_busy = '0;
		live_cfg = '{pqd_pkg::ORDER_MODE_RST, pqd_pkg::URGENT_MAX_RST,
			pqd_pkg::SERIOUS_MAX_RST, pqd_pkg::FIRST_END_RST, pqd_pkg::SECOND_END_RST};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// indexes past the register list must leave the defaults alone
		load_reg(CFG_SPARE_LO, 4'hF);
		load_reg(CFG_SPARE_HI, 4'h0);
		cfg_we <= 1'b0;

		add_row(1, 0, 0, 0,  1, 1, 1, 0, 0, 0, 0);
		add_row(1, 7, 0, 0,  1, 1, 2, 7, 8, 0, 0);
		add_row(1, 7, 1, 15, 1, 1, 3, 7, 9, 0, 0);
		for (k = 0; k < QDEPTH; k++)
			add_row(1, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(1, 0, 0, 0,  1, 0, 0, 0, 0, 1, 16);
		add_row(0, 0, 1, 9,  1, 1, 4, 7, 9, 0, 15);
		add_row(1, 4, 1, 5,  1, 1, 20, 4, 4, 0, 15);
		add_row(0, 0, 1, 0,  1, 0, 0, 0, 0, 0, 15);
		for (k = 0; k < opening_rows.size(); k++)
			offer(opening_rows[k].s, opening_rows[k].typed, opening_rows[k].want);
		settle();

		apply_settings(4'(MODE_FIFO), 0, 7, 0, 9);
		hold_left = 250;
		run_phase(80);

		// run with no idling on either side
		offer_gap_pct = 0;
		stall_pct = 0;
		apply_settings(4'(MODE_PRIO), 7, 7, 9, 9);
		run_phase(80);
		offer_gap_pct = 34;
		stall_pct = 34;

		apply_settings(4'(MODE_PRIO), 3, 5, 15, 2);
		run_phase(60);
		apply_settings(4'(MODE_FIFO), 0, 0, 0, 0);
		run_phase(80);
		apply_settings(4'(MODE_PRIO), 2, 4, 3, 7);
		run_phase(80);
		apply_settings(4'hF, 4'hE, 4'h6, 4'h5, 4'hC);
		run_phase(60);

		repeat (8) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("tb_priority_queue_pool_dispatcher: PASS");
		else
			$display("tb_priority_queue_pool_dispatcher: FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/pqd_pkg.sv
rtl/pqd_cell.sv
rtl/pqd_slot_pick.sv
rtl/priority_queue_pool_dispatcher.sv
sim/tb_priority_queue_pool_dispatcher.sv
